// ===== src/tpc_pkg.sv =====
`default_nettype none
package tpc_pkg;

  // fixed field widths and defaults
  localparam int CURV_OUT_BITS        = 31;
  localparam int FLOOR_BITS           = 20;
  localparam int FLOOR_RESET          = 17;
  localparam int COORD_BITS_DEF       = 24;
  localparam int COORD_FRAC_BITS_DEF  = 8;
  localparam int CURV_FRAC_BITS_DEF   = 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT,
    ST_EMIT_LAST
  } state_e;

  // compute steps of one interior point
  typedef enum logic [3:0] {
    OP_UX2,
    OP_UY2,
    OP_RT1,
    OP_VX2,
    OP_VY2,
    OP_RT2,
    OP_WX2,
    OP_WY2,
    OP_RT3,
    OP_P12,
    OP_P123,
    OP_CR1,
    OP_CR2,
    OP_DIV
  } op_e;

endpackage
`default_nettype wire

// ===== src/tpc_mac.sv =====
`default_nettype none
// Shift-add multiply-accumulate, one multiplier bit per cycle.
module tpc_mac #(
  parameter int DW    = 25,
  parameter int ACC_W = 76
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    clr_i,
  input  logic signed [ACC_W-1:0] mcand_i,
  input  logic        [DW-1:0]    mplier_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    done_o
);
  localparam int CW = $clog2(DW + 1);

  logic        [CW-1:0]    cnt_q;
  logic                    done_q;
  logic signed [ACC_W-1:0] acc_q, mcand_q;
  logic        [DW-1:0]    mplier_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      if (clr_i) acc_q <= '0;
    end else if (cnt_q != '0) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

// ===== src/tpc_sqrt.sv =====
`default_nettype none
// Restoring integer square root, one root bit per cycle.
module tpc_sqrt #(
  parameter int DW = 25
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*DW-1:0] val_i,
  output logic [DW-1:0]   root_o,
  output logic            done_o
);
  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0]   cnt_q;
  logic            done_q;
  logic [2*DW-1:0] val_q;
  logic [DW:0]     rem_q;
  logic [DW-1:0]   root_q;
  logic [DW+2:0]   rem_sh, trial, rem_sub;
  logic            ge;

  // trial subtract of one step
  always_comb begin
    rem_sh  = {rem_q, val_q[2*DW-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      val_q  <= val_q << 2;
      rem_q  <= ge ? rem_sub[DW:0] : rem_sh[DW:0];
      root_q <= {root_q[DW-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

// ===== src/tpc_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle; keeps the low QW bits
// and a sticky flag for any set bit above them.
module tpc_div #(
  parameter int MW    = 50,
  parameter int DEN_W = 75,
  parameter int NUM_W = 79,
  parameter int QW    = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MW-1:0]    mag_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QW-1:0]    quo_o,
  output logic             ovf_o,
  output logic             done_o
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [MW-1:0]    num_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [QW-1:0]    quo_q;
  logic             ovf_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_q, num_q[MW-1]};
    ge      = (rem_sh >= {1'b0, den_q});
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) done_q <= 1'b1;
      end
    end
  end

  // numerator bits come MSB first, zeros fill the shifted tail
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= mag_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (cnt_q != '0) begin
      num_q <= num_q << 1;
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
      ovf_q <= ovf_q | quo_q[QW-1];
    end
  end

  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

// ===== src/three_point_curvature_stream.sv =====
`default_nettype none
// Timing: a first point, or a second point that ends the track, answers in the
// cycle after acceptance; an interior point runs through the bit-serial
// multiplier, square root and divider in turn, and skips the divide when the
// length product is zero or under the floor.
// Throughput: one point in work at a time; the next is taken once the word leaves.
// Reset: window empty, floor register 17, no word pending.
module three_point_curvature_stream #(
  parameter int COORD_BITS      = tpc_pkg::COORD_BITS_DEF,
  parameter int COORD_FRAC_BITS = tpc_pkg::COORD_FRAC_BITS_DEF,
  parameter int CURV_FRAC_BITS  = tpc_pkg::CURV_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] x_coord_i,
  input  logic signed [COORD_BITS-1:0] y_coord_i,
  input  logic                         last_point_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [tpc_pkg::CURV_OUT_BITS-1:0] curvature_o,
  output logic                         last_of_track_o,
  input  logic                         cfg_we_i,
  input  logic [tpc_pkg::FLOOR_BITS-1:0] cfg_data_i
);
  import tpc_pkg::*;

  localparam int DW     = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DW;
  localparam int PROD_W = 3 * DW;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SH     = 1 + COORD_FRAC_BITS + CURV_FRAC_BITS;
  localparam int NUM_W  = SQ_W + SH;
  localparam int OW     = CURV_OUT_BITS;
  localparam logic [OW-1:0] POS_CAP = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] NEG_CAP = {1'b1, {(OW-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sext(input logic [DW-1:0] d);
    sext = {{(ACC_W-DW){d[DW-1]}}, d};
  endfunction

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] d);
    mag = d[DW-1] ? (~d + 1'b1) : d;
  endfunction

  function automatic logic [DW-1:0] dif(input logic [COORD_BITS-1:0] a,
                                        input logic [COORD_BITS-1:0] b);
    dif = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
  endfunction

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [FLOOR_BITS-1:0] floor_q;
  logic [COORD_BITS-1:0] newer_x_q, newer_y_q, older_x_q, older_y_q;
  logic [1:0]            seen_q;
  logic [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic                  fin_q, neg_q;
  logic [DW-1:0]         l1_q, l2_q, l3_q;
  logic [PROD_W-1:0]     prod_q;
  logic [OW-1:0]         res_q, res_d;
  logic                  res_we;

  logic                  out_valid_q, out_last_q;
  logic [OW-1:0]         out_curv_q;
  logic                  out_load;
  logic [OW-1:0]         out_curv_d;
  logic                  out_last_d;

  logic                  accept;
  logic [DW-1:0]         ux, uy, vx, vy, wx, wy;

  logic                    mac_start, mac_clr, mac_done;
  logic signed [ACC_W-1:0] mac_mcand, acc;
  logic [DW-1:0]           mac_mplier;
  logic                    rt_start, rt_done;
  logic [DW-1:0]           root;
  logic                    div_start, div_done, div_ovf;
  logic [OW-1:0]           quo;
  logic                    degen;
  logic                    big;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = !(state_q == ST_IDLE && !out_valid_q);

  // side differences of the captured triangle
  assign ux = dif(ax_q, bx_q);
  assign uy = dif(ay_q, by_q);
  assign vx = dif(bx_q, cx_q);
  assign vy = dif(by_q, cy_q);
  assign wx = dif(ax_q, cx_q);
  assign wy = dif(ay_q, cy_q);

  assign degen = (prod_q == '0) || (prod_q < PROD_W'(floor_q));

  // saturation of the divider result
  always_comb begin
    if (neg_q) begin
      big   = div_ovf || (quo > NEG_CAP);
      res_d = big ? NEG_CAP : (~quo + 1'b1);
    end else begin
      big   = div_ovf || (quo > POS_CAP);
      res_d = big ? POS_CAP : quo;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mac_mcand  = '0;
    mac_mplier = '0;
    mac_clr    = 1'b1;
    case (op_q)
      OP_UX2:  begin mac_mcand = ACC_W'(mag(ux)); mac_mplier = mag(ux); end
      OP_UY2:  begin mac_mcand = ACC_W'(mag(uy)); mac_mplier = mag(uy); mac_clr = 1'b0; end
      OP_VX2:  begin mac_mcand = ACC_W'(mag(vx)); mac_mplier = mag(vx); end
      OP_VY2:  begin mac_mcand = ACC_W'(mag(vy)); mac_mplier = mag(vy); mac_clr = 1'b0; end
      OP_WX2:  begin mac_mcand = ACC_W'(mag(wx)); mac_mplier = mag(wx); end
      OP_WY2:  begin mac_mcand = ACC_W'(mag(wy)); mac_mplier = mag(wy); mac_clr = 1'b0; end
      OP_P12:  begin mac_mcand = ACC_W'(l1_q); mac_mplier = l2_q; end
      OP_P123: begin mac_mcand = acc; mac_mplier = l3_q; end
      OP_CR1:  begin
        mac_mcand  = wy[DW-1] ? -sext(ux) : sext(ux);
        mac_mplier = mag(wy);
      end
      OP_CR2:  begin
        mac_mcand  = wx[DW-1] ? sext(uy) : -sext(uy);
        mac_mplier = mag(wx);
        mac_clr    = 1'b0;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    mac_start  = 1'b0;
    rt_start   = 1'b0;
    div_start  = 1'b0;
    res_we     = 1'b0;
    out_load   = 1'b0;
    out_curv_d = '0;
    out_last_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (seen_q == 2'd0) begin
            out_load   = 1'b1;
            out_last_d = last_point_i;
          end else if (seen_q == 2'd1) begin
            if (last_point_i) begin
              out_load   = 1'b1;
              out_last_d = 1'b1;
            end
          end else begin
            op_d    = OP_UX2;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (op_q == OP_RT1 || op_q == OP_RT2 || op_q == OP_RT3) rt_start = 1'b1;
        else if (op_q == OP_DIV) div_start = 1'b1;
        else mac_start = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_done || rt_done || div_done) begin
          state_d = ST_ISSUE;
          unique case (op_q)
            OP_UX2:  op_d = OP_UY2;
            OP_UY2:  op_d = OP_RT1;
            OP_RT1:  op_d = OP_VX2;
            OP_VX2:  op_d = OP_VY2;
            OP_VY2:  op_d = OP_RT2;
            OP_RT2:  op_d = OP_WX2;
            OP_WX2:  op_d = OP_WY2;
            OP_WY2:  op_d = OP_RT3;
            OP_RT3:  op_d = OP_P12;
            OP_P12:  op_d = OP_P123;
            OP_P123: op_d = OP_CR1;
            OP_CR1:  op_d = OP_CR2;
            OP_CR2:  begin
              op_d = OP_DIV;
              if (degen) state_d = ST_EMIT;
            end
            OP_DIV:  begin
              res_we  = 1'b1;
              state_d = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (!out_valid_q) begin
          out_load   = 1'b1;
          out_curv_d = res_q;
          state_d    = fin_q ? ST_EMIT_LAST : ST_IDLE;
        end
      end
      ST_EMIT_LAST: begin
        if (!out_valid_q) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_UX2;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // floor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) floor_q <= FLOOR_BITS'(FLOOR_RESET);
    else if (cfg_we_i) floor_q <= cfg_data_i;
  end

  // point window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      newer_x_q <= '0;
      newer_y_q <= '0;
      older_x_q <= '0;
      older_y_q <= '0;
    end else if (accept) begin
      if (last_point_i) begin
        seen_q    <= '0;
        newer_x_q <= '0;
        newer_y_q <= '0;
        older_x_q <= '0;
        older_y_q <= '0;
      end else begin
        seen_q    <= (seen_q == 2'd0) ? 2'd1 : 2'd2;
        older_x_q <= newer_x_q;
        older_y_q <= newer_y_q;
        newer_x_q <= x_coord_i;
        newer_y_q <= y_coord_i;
      end
    end
  end

  // triangle capture and intermediate results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q  <= older_x_q;
      ay_q  <= older_y_q;
      bx_q  <= newer_x_q;
      by_q  <= newer_y_q;
      cx_q  <= x_coord_i;
      cy_q  <= y_coord_i;
      fin_q <= last_point_i;
      res_q <= '0;
    end
    if (state_q == ST_WAIT && rt_done) begin
      if (op_q == OP_RT1) l1_q <= root;
      if (op_q == OP_RT2) l2_q <= root;
      if (op_q == OP_RT3) l3_q <= root;
    end
    if (state_q == ST_WAIT && mac_done && op_q == OP_P123) prod_q <= acc[PROD_W-1:0];
    if (state_q == ST_WAIT && mac_done && op_q == OP_CR2) neg_q <= acc[ACC_W-1];
    if (res_we) res_q <= res_d;
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_curv_q <= out_curv_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign curvature_o     = out_curv_q;
  assign last_of_track_o = out_last_q;

  tpc_mac #(.DW(DW), .ACC_W(ACC_W)) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mac_start),
    .clr_i    (mac_clr),
    .mcand_i  (mac_mcand),
    .mplier_i (mac_mplier),
    .acc_o    (acc),
    .done_o   (mac_done)
  );

  tpc_sqrt #(.DW(DW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_start),
    .val_i   (acc[SQ_W-1:0]),
    .root_o  (root),
    .done_o  (rt_done)
  );

  // cross product magnitude fits SQ_W bits
  logic [SQ_W-1:0] crs_mag;
  assign crs_mag = neg_q ? SQ_W'(-acc) : acc[SQ_W-1:0];

  tpc_div #(.MW(SQ_W), .DEN_W(PROD_W), .NUM_W(NUM_W), .QW(OW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (crs_mag),
    .den_i   (prod_q),
    .quo_o   (quo),
    .ovf_o   (div_ovf),
    .done_o  (div_done)
  );

endmodule
`default_nettype wire
